// ===== sv/bounded_ordered_list_engine_defines.svh =====
// Assertion macros used by the checker file of the bounded ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BOLE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define BOLE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bole_pkg.sv =====
// Types and constants shared by the bounded ordered list engine modules.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int DEF_CAPACITY     = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int PORT_PAY_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR      = 3'd0,
        FUNC_INS_FRONT  = 3'd1,
        FUNC_INS_REAR   = 3'd2,
        FUNC_INS_SORTED = 3'd3,
        FUNC_REM_FRONT  = 3'd4,
        FUNC_REM_REAR   = 3'd5,
        FUNC_REM_KEY    = 3'd6
    } func_e;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC,
        ST_WALK,
        ST_LINK_A,
        ST_LINK_B,
        ST_UNLINK_A,
        ST_UNLINK_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic data;
        logic next;
        logic prior;
    } node_wr_en_t;

endpackage

// ===== sv/bole_node_ram.sv =====
// Node store of the list: key, payload, next link and prior link for every slot.
`timescale 1ns / 1ps

module bole_node_ram #(
    parameter int DEPTH  = 16,
    parameter int PAY_W  = 32
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic signed [bole_pkg::KEY_W-1:0] rd_key,
    output logic [PAY_W-1:0]              rd_pay,
    output logic [$clog2(DEPTH+1)-1:0]    rd_next,
    output logic [$clog2(DEPTH+1)-1:0]    rd_prior,
    input  bole_pkg::node_wr_en_t         wr_en,
    input  logic [$clog2(DEPTH)-1:0]      data_addr,
    input  logic signed [bole_pkg::KEY_W-1:0] wr_key,
    input  logic [PAY_W-1:0]              wr_pay,
    input  logic [$clog2(DEPTH)-1:0]      next_addr,
    input  logic [$clog2(DEPTH+1)-1:0]    wr_next,
    input  logic [$clog2(DEPTH)-1:0]      prior_addr,
    input  logic [$clog2(DEPTH+1)-1:0]    wr_prior
);
    import bole_pkg::*;

    localparam int LINK_W = $clog2(DEPTH + 1);

    logic signed [KEY_W-1:0] key_mem   [DEPTH];
    logic [PAY_W-1:0]        pay_mem   [DEPTH];
    logic [LINK_W-1:0]       next_mem  [DEPTH];
    logic [LINK_W-1:0]       prior_mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en.data) begin
            key_mem[data_addr] <= wr_key;
            pay_mem[data_addr] <= wr_pay;
        end
        if (wr_en.next) begin
            next_mem[next_addr] <= wr_next;
        end
        if (wr_en.prior) begin
            prior_mem[prior_addr] <= wr_prior;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_key   <= key_mem[rd_addr];
            rd_pay   <= pay_mem[rd_addr];
            rd_next  <= next_mem[rd_addr];
            rd_prior <= prior_mem[rd_addr];
        end
    end

endmodule

// ===== sv/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: sequencer, list registers and node store.
//
// Channel   Ports        Direction  Word
// input     s_*          in         operation code, key, payload
// result    m_*          out        status, removed key, removed payload, entry count
//
// Sorted insert and removal by key walk the list one entry per cycle through the single
// read port of the node store; the other operations do not walk the list.
// Reset is synchronous and leaves an empty list at once, with no clearing pass.
// A result word waiting on m_ready holds the next word in its final step only.
`timescale 1ns / 1ps

module bounded_ordered_list_engine #(
    parameter int CAPACITY     = bole_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = bole_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [bole_pkg::FUNC_W-1:0]            s_func,
    input  logic signed [bole_pkg::KEY_W-1:0]      s_item_key,
    input  logic [bole_pkg::PORT_PAY_W-1:0]        s_item_payload,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [bole_pkg::STATUS_W-1:0]          m_status,
    output logic signed [bole_pkg::KEY_W-1:0]      m_out_key,
    output logic [bole_pkg::PORT_PAY_W-1:0]        m_out_payload,
    output logic [bole_pkg::COUNT_W-1:0]           m_entry_count
);
    import bole_pkg::*;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int SLOT_W    = $clog2(CAPACITY + 1);
    localparam int CNT_EXT_W = SLOT_W + COUNT_W;
    localparam logic [SLOT_W-1:0] NONE = SLOT_W'(CAPACITY);

    state_t                    state_reg, state_next;
    logic [FUNC_W-1:0]         func_reg, func_next;
    logic signed [KEY_W-1:0]   key_reg, key_next;
    logic [PAYLOAD_BITS-1:0]   pay_reg, pay_next;
    logic [SLOT_W-1:0]         first_reg, first_next;
    logic [SLOT_W-1:0]         last_reg, last_next;
    logic [SLOT_W-1:0]         free_reg, free_next;
    logic [SLOT_W-1:0]         fresh_reg, fresh_next;
    logic [SLOT_W-1:0]         count_reg, count_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SLOT_W-1:0]         tgt_reg, tgt_next;
    logic [SLOT_W-1:0]         prev_reg, prev_next;
    logic [SLOT_W-1:0]         succ_reg, succ_next;
    status_e                   status_reg, status_next;
    logic signed [KEY_W-1:0]   okey_reg, okey_next;
    logic [PORT_PAY_W-1:0]     opay_reg, opay_next;

    logic                      m_valid_reg, m_valid_next;
    status_e                   m_status_reg, m_status_next;
    logic signed [KEY_W-1:0]   m_key_reg, m_key_next;
    logic [PORT_PAY_W-1:0]     m_pay_reg, m_pay_next;
    logic [COUNT_W-1:0]        m_count_reg, m_count_next;

    logic                      rd_en;
    logic [SLOT_W-1:0]         rd_slot;
    logic signed [KEY_W-1:0]   rd_key;
    logic [PAYLOAD_BITS-1:0]   rd_pay;
    logic [SLOT_W-1:0]         rd_next;
    logic [SLOT_W-1:0]         rd_prior;
    node_wr_en_t               wr_en;
    logic [SLOT_W-1:0]         data_slot, next_slot, prior_slot;
    logic [SLOT_W-1:0]         wr_next, wr_prior;

    logic [63:0]               pay_in_ext;
    logic [63:0]               pay_out_ext;
    logic [CNT_EXT_W-1:0]      count_ext;
    logic                      walk_on;

    assign pay_in_ext  = {32'd0, s_item_payload};
    assign pay_out_ext = 64'(rd_pay);
    assign count_ext   = CNT_EXT_W'(count_reg);
    assign walk_on     = (func_reg == FUNC_INS_SORTED) ? (rd_key < key_reg)
                                                      : (rd_key != key_reg);

    bole_node_ram #(
        .DEPTH (CAPACITY),
        .PAY_W (PAYLOAD_BITS)
    ) u_node_ram (
        .clk        (aclk),
        .rd_en      (rd_en),
        .rd_addr    (rd_slot[IDX_W-1:0]),
        .rd_key     (rd_key),
        .rd_pay     (rd_pay),
        .rd_next    (rd_next),
        .rd_prior   (rd_prior),
        .wr_en      (wr_en),
        .data_addr  (data_slot[IDX_W-1:0]),
        .wr_key     (key_reg),
        .wr_pay     (pay_reg),
        .next_addr  (next_slot[IDX_W-1:0]),
        .wr_next    (wr_next),
        .prior_addr (prior_slot[IDX_W-1:0]),
        .wr_prior   (wr_prior)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= NONE;
            last_reg    <= NONE;
            free_reg    <= '0;
            fresh_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            free_reg    <= free_next;
            fresh_reg   <= fresh_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        slot_reg     <= slot_next;
        tgt_reg      <= tgt_next;
        prev_reg     <= prev_next;
        succ_reg     <= succ_next;
        status_reg   <= status_next;
        okey_reg     <= okey_next;
        opay_reg     <= opay_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_pay_reg    <= m_pay_next;
        m_count_reg  <= m_count_next;
    end

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        tgt_next      = tgt_reg;
        prev_next     = prev_reg;
        succ_next     = succ_reg;
        status_next   = status_reg;
        okey_next     = okey_reg;
        opay_next     = opay_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_pay_next    = m_pay_reg;
        m_count_next  = m_count_reg;
        s_ready       = 1'b0;
        rd_en         = 1'b0;
        rd_slot       = first_reg;
        wr_en         = '0;
        data_slot     = slot_reg;
        next_slot     = slot_reg;
        prior_slot    = slot_reg;
        wr_next       = tgt_reg;
        wr_prior      = prev_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = s_func;
                    key_next   = s_item_key;
                    pay_next   = pay_in_ext[PAYLOAD_BITS-1:0];
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                status_next = STATUS_OK;
                okey_next   = '0;
                opay_next   = '0;
                state_next  = ST_DONE;
                case (func_reg)
                    FUNC_CLEAR: begin
                        first_next = NONE;
                        last_next  = NONE;
                        free_next  = '0;
                        fresh_next = '0;
                        count_next = '0;
                    end
                    FUNC_INS_FRONT, FUNC_INS_REAR, FUNC_INS_SORTED: begin
                        if (free_reg == NONE) begin
                            status_next = STATUS_FULL;
                        end else begin
                            slot_next  = free_reg;
                            rd_en      = 1'b1;
                            rd_slot    = free_reg;
                            state_next = ST_ALLOC;
                        end
                    end
                    FUNC_REM_FRONT, FUNC_REM_REAR: begin
                        slot_next = (func_reg == FUNC_REM_FRONT) ? first_reg : last_reg;
                        rd_slot   = slot_next;
                        if (slot_next == NONE) begin
                            status_next = STATUS_MISS;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = ST_UNLINK_A;
                        end
                    end
                    FUNC_REM_KEY: begin
                        tgt_next = first_reg;
                        if (first_reg == NONE) begin
                            status_next = STATUS_MISS;
                        end else begin
                            rd_en      = 1'b1;
                            rd_slot    = first_reg;
                            state_next = ST_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ALLOC: begin
                if (slot_reg == fresh_reg) begin
                    free_next  = slot_reg + 1'b1;
                    fresh_next = fresh_reg + 1'b1;
                end else begin
                    free_next = rd_next;
                end
                state_next = ST_LINK_A;
                case (func_reg)
                    FUNC_INS_FRONT: begin
                        tgt_next  = first_reg;
                        prev_next = NONE;
                    end
                    FUNC_INS_REAR: begin
                        tgt_next  = NONE;
                        prev_next = last_reg;
                    end
                    default: begin
                        tgt_next  = first_reg;
                        prev_next = last_reg;
                        if (first_reg != NONE) begin
                            rd_en      = 1'b1;
                            rd_slot    = first_reg;
                            state_next = ST_WALK;
                        end
                    end
                endcase
            end
            ST_WALK: begin
                if (walk_on) begin
                    if (rd_next == NONE) begin
                        tgt_next  = NONE;
                        prev_next = last_reg;
                        if (func_reg == FUNC_INS_SORTED) begin
                            state_next = ST_LINK_A;
                        end else begin
                            status_next = STATUS_MISS;
                            state_next  = ST_DONE;
                        end
                    end else begin
                        tgt_next = rd_next;
                        rd_en    = 1'b1;
                        rd_slot  = rd_next;
                    end
                end else if (func_reg == FUNC_INS_SORTED) begin
                    prev_next  = rd_prior;
                    state_next = ST_LINK_A;
                end else begin
                    slot_next  = tgt_reg;
                    state_next = ST_UNLINK_A;
                end
            end
            ST_LINK_A: begin
                wr_en.data  = 1'b1;
                wr_en.next  = 1'b1;
                wr_en.prior = 1'b1;
                wr_next     = tgt_reg;
                wr_prior    = prev_reg;
                state_next  = ST_LINK_B;
            end
            ST_LINK_B: begin
                next_slot  = prev_reg;
                wr_next    = slot_reg;
                prior_slot = tgt_reg;
                wr_prior   = slot_reg;
                if (prev_reg != NONE) begin
                    wr_en.next = 1'b1;
                end else begin
                    first_next = slot_reg;
                end
                if (tgt_reg != NONE) begin
                    wr_en.prior = 1'b1;
                end else begin
                    last_next = slot_reg;
                end
                count_next  = count_reg + 1'b1;
                status_next = STATUS_OK;
                state_next  = ST_DONE;
            end
            ST_UNLINK_A: begin
                okey_next  = rd_key;
                opay_next  = pay_out_ext[PORT_PAY_W-1:0];
                prev_next  = rd_prior;
                succ_next  = rd_next;
                wr_en.next = 1'b1;
                next_slot  = slot_reg;
                wr_next    = free_reg;
                prior_slot = rd_next;
                wr_prior   = rd_prior;
                if (rd_next != NONE) begin
                    wr_en.prior = 1'b1;
                end else begin
                    last_next = rd_prior;
                end
                if (rd_prior == NONE) begin
                    first_next = rd_next;
                end
                free_next   = slot_reg;
                count_next  = count_reg - 1'b1;
                status_next = STATUS_OK;
                state_next  = ST_UNLINK_B;
            end
            ST_UNLINK_B: begin
                next_slot = prev_reg;
                wr_next   = succ_reg;
                if (prev_reg != NONE) begin
                    wr_en.next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_key_next    = okey_reg;
                    m_pay_next    = opay_reg;
                    m_count_next  = count_ext[COUNT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_key     = m_key_reg;
    assign m_out_payload = m_pay_reg;
    assign m_entry_count = m_count_reg;

endmodule

// ===== sv/bole_checker.sv =====
// Port-level assertion checker for the bounded ordered list engine, with its bind.
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_defines.svh"

module bole_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic [bole_pkg::FUNC_W-1:0]            s_func,
    input logic signed [bole_pkg::KEY_W-1:0]      s_item_key,
    input logic [bole_pkg::PORT_PAY_W-1:0]        s_item_payload,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [bole_pkg::STATUS_W-1:0]          m_status,
    input logic signed [bole_pkg::KEY_W-1:0]      m_out_key,
    input logic [bole_pkg::PORT_PAY_W-1:0]        m_out_payload,
    input logic [bole_pkg::COUNT_W-1:0]           m_entry_count
);
    import bole_pkg::*;

    // A result word that is not taken stays on the port unchanged.
    `BOLE_ASSERT_CLK(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_key) && $stable(m_out_payload) && $stable(m_entry_count), "result word changed while stalled")

    // A refused or missed operation reports no removed entry.
    `BOLE_ASSERT_CLK(a_miss_zero, aclk, aresetn, m_valid && m_status != STATUS_OK |-> m_out_key == '0 && m_out_payload == '0, "failed operation returned entry data")

    // Acceptance of a word with no result pending does not itself raise a result word.
    `BOLE_ASSERT_CLK(a_no_early_result, aclk, aresetn, s_valid && s_ready && !m_valid |=> !m_valid, "result word appeared in the cycle after acceptance")

    // Reset leaves no result word pending.
    `BOLE_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the bounded ordered list engine, with its list tracker and stimulus.
`timescale 1ns / 1ps

module tb;
    import bole_pkg::*;

    localparam int CAP            = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = CAP + 12;
    localparam int PHASE_WORDS    = 410;

    localparam logic [FUNC_W-1:0]       FUNC_UNUSED = 3'd7;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_TOP     = 32'sh7FFF_FFFE;
    localparam logic signed [KEY_W-1:0] KEY_INT_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PORT_PAY_W-1:0]   payload;
    } entry_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] key;
        logic [PORT_PAY_W-1:0]   payload;
        logic [COUNT_W-1:0]      count;
    } list_result_t;

    class list_scoreboard;
        entry_t       entries[$];
        list_result_t awaited[$];
        int errors;
        int noted;
        int checked;
        int refused;
        int misses;
        int deepest;

        function new();
            errors  = 0;
            noted   = 0;
            checked = 0;
            refused = 0;
            misses  = 0;
            deepest = 0;
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("[%0t] mismatch in %s: expected %h, got %h", $time, what, want, got);
        endtask

        function list_result_t apply_operation(logic [FUNC_W-1:0] func,
                                               logic signed [KEY_W-1:0] key,
                                               logic [PORT_PAY_W-1:0] payload);
            list_result_t r;
            entry_t       e;
            int           pos;
            r.status  = STATUS_OK;
            r.key     = '0;
            r.payload = '0;
            e.key     = key;
            e.payload = payload;
            case (func)
                FUNC_CLEAR: entries.delete();
                FUNC_INS_FRONT, FUNC_INS_REAR, FUNC_INS_SORTED: begin
                    if (entries.size() >= CAP) begin
                        r.status = STATUS_FULL;
                    end else if (func == FUNC_INS_FRONT) begin
                        entries.push_front(e);
                    end else if (func == FUNC_INS_REAR) begin
                        entries.push_back(e);
                    end else begin
                        pos = 0;
                        while (pos < entries.size() && entries[pos].key < key)
                            pos++;
                        if (pos == entries.size())
                            entries.push_back(e);
                        else
                            entries.insert(pos, e);
                    end
                end
                FUNC_REM_FRONT, FUNC_REM_REAR, FUNC_REM_KEY: begin
                    if (entries.size() == 0) begin
                        pos = -1;
                    end else if (func == FUNC_REM_FRONT) begin
                        pos = 0;
                    end else if (func == FUNC_REM_REAR) begin
                        pos = entries.size() - 1;
                    end else begin
                        pos = 0;
                        while (pos < entries.size() && entries[pos].key != key)
                            pos++;
                        if (pos == entries.size())
                            pos = -1;
                    end
                    if (pos < 0) begin
                        r.status = STATUS_MISS;
                    end else begin
                        r.key     = entries[pos].key;
                        r.payload = entries[pos].payload;
                        entries.delete(pos);
                    end
                end
                default: ;
            endcase
            r.count = COUNT_W'(entries.size());
            return r;
        endfunction

        function void note_operation(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                                     logic [PORT_PAY_W-1:0] payload);
            list_result_t r;
            r = apply_operation(func, key, payload);
            awaited.push_back(r);
            noted++;
            if (r.status == STATUS_FULL)
                refused++;
            if (r.status == STATUS_MISS)
                misses++;
            if (r.count > deepest)
                deepest = r.count;
        endfunction

        task check_result(logic [STATUS_W-1:0] status, logic signed [KEY_W-1:0] key,
                          logic [PORT_PAY_W-1:0] payload, logic [COUNT_W-1:0] count);
            list_result_t want;
            if (awaited.size() == 0) begin
                report("unexpected result word status", '0, 32'(status));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (status !== want.status)
                report("status", 32'(want.status), 32'(status));
            if (key !== want.key)
                report("out_key", want.key, key);
            if (payload !== want.payload)
                report("out_payload", want.payload, payload);
            if (count !== want.count)
                report("entry_count", 32'(want.count), 32'(count));
        endtask
    endclass

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [FUNC_W-1:0]       s_func         = '0;
    logic signed [KEY_W-1:0] s_item_key     = '0;
    logic [PORT_PAY_W-1:0]   s_item_payload = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic signed [KEY_W-1:0] m_out_key;
    logic [PORT_PAY_W-1:0]   m_out_payload;
    logic [COUNT_W-1:0]      m_entry_count;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int idle_cycles = 0;

    list_scoreboard sb;

    bounded_ordered_list_engine dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_item_key     (s_item_key),
        .s_item_payload (s_item_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_key      (m_out_key),
        .m_out_payload  (m_out_payload),
        .m_entry_count  (m_entry_count)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_status, m_out_key, m_out_payload, m_entry_count);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no word has moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                             logic [PORT_PAY_W-1:0] payload);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_item_key     <= key;
        s_item_payload <= payload;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_operation(func, key, payload);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 25)
            return $urandom;
        case ($urandom_range(7))
            0:       return KEY_MIN;
            1:       return KEY_TOP;
            2:       return '0;
            3:       return -1;
            default: return $signed($urandom_range(20)) - 10;
        endcase
    endfunction

    // Blocks of forty words alternate between filling and draining the list, so that both
    // the full and the empty list are met often.
    task automatic run_random(int words);
        logic [FUNC_W-1:0] func;
        int                pick;
        int                insert_pct;
        for (int i = 0; i < words; i++) begin
            insert_pct = ((i / 40) % 2 == 0) ? 70 : 30;
            pick = $urandom_range(99);
            if (pick < 2)
                func = FUNC_CLEAR;
            else if (pick < 3)
                func = FUNC_UNUSED;
            else if (pick < insert_pct)
                func = FUNC_W'(FUNC_INS_FRONT + $urandom_range(2));
            else
                func = FUNC_W'(FUNC_REM_FRONT + $urandom_range(2));
            send_word(func, pick_key(), $urandom);
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(FUNC_REM_FRONT, '0, '0);
        send_word(FUNC_REM_REAR, '0, '0);
        send_word(FUNC_REM_KEY, KEY_MIN, '1);
        send_word(FUNC_UNUSED, KEY_TOP, '1);
        send_word(FUNC_INS_SORTED, KEY_INT_MAX, 32'hFFFF_FFFF);
        send_word(FUNC_INS_SORTED, KEY_MIN, 32'h0000_0000);
        send_word(FUNC_INS_FRONT, '0, 32'hAAAA_AAAA);
        send_word(FUNC_INS_REAR, KEY_TOP, 32'h5555_5555);
        send_word(FUNC_INS_SORTED, '0, 32'h0000_0001);
        send_word(FUNC_UNUSED, '0, '0);
        send_word(FUNC_REM_KEY, '0, '0);
        send_word(FUNC_REM_KEY, KEY_INT_MAX, '0);
        send_word(FUNC_REM_KEY, 32'sd12345, '0);
        send_word(FUNC_INS_SORTED, -1, 32'h8000_0001);
        send_word(FUNC_REM_FRONT, '0, '0);
        send_word(FUNC_REM_REAR, '0, '0);
        send_word(FUNC_CLEAR, '0, '0);
        send_word(FUNC_REM_KEY, '0, '0);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 0;
        run_random(PHASE_WORDS);
        wait_drained();
        idle_pct  = 66;
        stall_pct = 0;
        run_random(PHASE_WORDS);
        wait_drained();
        idle_pct  = 0;
        stall_pct = 66;
        run_random(PHASE_WORDS);
        wait_drained();
        idle_pct  = 22;
        stall_pct = 22;
        run_random(PHASE_WORDS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d operation words under four idling patterns; %0d results checked.",
                 sb.noted, sb.checked);
        $display("Inserts refused on a full list: %0d, removals that found nothing: %0d, %s %0d.",
                 sb.refused, sb.misses, "deepest list", sb.deepest);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== bounded_ordered_list_engine.f =====
+incdir+sv
sv/bole_pkg.sv
sv/bole_node_ram.sv
sv/bounded_ordered_list_engine.sv
sv/bole_checker.sv
sim/tb.sv
